// ===== hw/rtl/mips_subset_execute_unit_defines.svh =====
// ============================================================================
// MIPS subset execute unit: assertion macros
// Shared assertion macros for the execute unit. They expect signals named
// clock and reset in the scope where they are used, and they expand to
// nothing when SYNTHESIS is defined.
// ============================================================================
`ifndef MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside of reset.
`define MSE_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");
// Next-cycle implication, checked at every rising edge outside of reset.
`define MSE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");
`else
`define MSE_ASSERT_IMPLY(label, ante, cons)
`define MSE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/mse_pkg.sv =====
// ============================================================================
// MIPS subset execute unit: shared package
// Widths, operation and error codes, and the structures that pass between
// the modules of the execute unit.
// ============================================================================
`default_nettype none

package mse_pkg;

   localparam int XLEN              = 32;
   localparam int BYTE_W            = 8;
   localparam int NUM_REGS          = 32;
   localparam int REG_AW            = 5;
   localparam int REG_NUM_W         = 6;
   localparam int FUNC_W            = 4;
   localparam int MEM_BYTES_DEFAULT = 65536;

   // Register that comes out of reset holding the data memory size.
   localparam logic [REG_AW-1:0] REG_MEM_SIZE = 5'd31;
   localparam logic [REG_AW-1:0] REG_ZERO     = 5'd0;

   typedef enum logic [FUNC_W-1:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_ADDI = 4'd3,
      OP_BEQ  = 4'd4,
      OP_BNE  = 4'd5,
      OP_SLT  = 4'd6,
      OP_LW   = 4'd7,
      OP_SW   = 4'd8,
      OP_J    = 4'd9
   } op_type;

   typedef enum logic [2:0] {
      ERR_OK     = 3'd0,
      ERR_REG    = 3'd1,
      ERR_ALIGN  = 3'd2,
      ERR_TARGET = 3'd3,
      ERR_OPCODE = 3'd4
   } err_type;

   typedef struct packed {
      logic [FUNC_W-1:0]    func;
      logic [REG_NUM_W-1:0] first_reg;
      logic [REG_NUM_W-1:0] second_reg;
      logic [REG_NUM_W-1:0] third_reg;
      logic [XLEN-1:0]      immediate;
      logic [XLEN-1:0]      pc;
   } instr_type;

   typedef struct packed {
      err_type         err;
      logic [XLEN-1:0] next_pc;
      logic            rf_we;
      logic            load;
      logic [XLEN-1:0] result;
      logic            mem_we;
      logic [XLEN-1:0] mem_addr;
      logic [XLEN-1:0] mem_data;
   } exec_type;

   typedef struct packed {
      logic              we;
      logic [REG_AW-1:0] addr;
      logic [XLEN-1:0]   data;
   } wb_type;

endpackage

`default_nettype wire

// ===== hw/rtl/mips_subset_execute_unit.sv =====
// ============================================================================
// MIPS subset execute unit
// Executes one decoded instruction per transfer against a register file and
// a byte-addressed little-endian data memory and returns the next address.
// ============================================================================
// The unit takes one instruction transfer per clock, unless it is stalling,
// and returns one result transfer per instruction, in order. Between taking
// an instruction and returning its result lie the registered register-file
// read, the registered data-memory read used by loads (with register
// write-back at its end), and the output register. Back-to-back dependent
// instructions, loads included, run at full rate because results still in
// flight are bypassed to the operand read. A stall on the result side holds
// the whole pipeline. After reset a clearing pass zeroes the data memory,
// one row of four bytes per cycle; no instruction is taken until it ends.
// MEM_BYTES must be a power of two.
`default_nettype none
`include "mips_subset_execute_unit_defines.svh"

module mips_subset_execute_unit
   import mse_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [FUNC_W-1:0]           req_func,
   input  logic [REG_NUM_W-1:0]        req_first_reg,
   input  logic [REG_NUM_W-1:0]        req_second_reg,
   input  logic [REG_NUM_W-1:0]        req_third_reg,
   input  logic signed [XLEN-1:0]      req_immediate,
   input  logic signed [XLEN-1:0]      req_pc,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [XLEN-1:0]      rsp_next_pc,
   output logic [2:0]                  rsp_error_code
);

   localparam int MEM_AW = $clog2(MEM_BYTES);

   // Pipeline control.
   logic            adv;
   logic            accept;
   logic            clear_busy;

   // Operand read stage.
   instr_type       s1_instr_in;
   instr_type       s1_instr_ff;
   logic            s1_valid_ff;
   logic            use_first;
   logic            use_cmp;
   logic [REG_AW-1:0] rd_addr0;
   logic [REG_AW-1:0] rd_addr1;
   logic [XLEN-1:0] op_x;
   logic [XLEN-1:0] op_y;
   exec_type        ex;
   logic            dm_wr_en;

   // Write-back stage.
   logic            s2_valid_ff;
   logic            s2_rf_we_ff;
   logic            s2_load_ff;
   logic [REG_AW-1:0] s2_wa_ff;
   logic [XLEN-1:0] s2_result_ff;
   logic [XLEN-1:0] s2_next_pc_ff;
   err_type         s2_err_ff;
   logic [XLEN-1:0] load_word;
   wb_type          rf_pend;
   wb_type          rf_commit;

   // Output register.
   logic            out_valid_ff;
   logic [XLEN-1:0] out_next_pc_ff;
   err_type         out_err_ff;

   // The pipeline moves as a whole whenever the output register is empty
   // or its result is being transferred in this cycle.
   assign adv       = !out_valid_ff || !rsp_stall;
   assign req_stall = clear_busy || !adv;
   assign accept    = req_valid && !req_stall;

   assign s1_instr_in = '{
      func:       req_func,
      first_reg:  req_first_reg,
      second_reg: req_second_reg,
      third_reg:  req_third_reg,
      immediate:  req_immediate,
      pc:         req_pc
   };

   // Read port 0 supplies the first source, the first compare register or
   // the store data; read port 1 the second source, the second compare
   // register or the load/store base.
   assign use_first = (req_func == OP_BEQ) || (req_func == OP_BNE) || (req_func == OP_SW);
   assign use_cmp   = (req_func == OP_BEQ) || (req_func == OP_BNE);
   assign rd_addr0  = use_first ? req_first_reg[REG_AW-1:0] : req_second_reg[REG_AW-1:0];
   assign rd_addr1  = use_cmp ? req_second_reg[REG_AW-1:0] : req_third_reg[REG_AW-1:0];

   // The write-back stage's register write is visible to the operand read
   // right away; it commits to the register file when the pipeline moves.
   assign rf_pend.we   = s2_valid_ff && s2_rf_we_ff;
   assign rf_pend.addr = s2_wa_ff;
   assign rf_pend.data = s2_load_ff ? load_word : s2_result_ff;

   assign rf_commit.we   = rf_pend.we && adv;
   assign rf_commit.addr = rf_pend.addr;
   assign rf_commit.data = rf_pend.data;

   mse_regfile #(
      .MEM_BYTES (MEM_BYTES)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (adv),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .pend     (rf_pend),
      .commit   (rf_commit),
      .rd_data0 (op_x),
      .rd_data1 (op_y)
   );

   mse_execute u_execute (
      .instr (s1_instr_ff),
      .op_x  (op_x),
      .op_y  (op_y),
      .ex    (ex)
   );

   // Stores write in the operand stage and loads read there too, so memory
   // accesses stay in program order and need no bypass.
   assign dm_wr_en = adv && s1_valid_ff && ex.mem_we;

   mse_datamem #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datamem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (adv),
      .rd_row     (ex.mem_addr[MEM_AW-1:2]),
      .wr_en      (dm_wr_en),
      .wr_addr    (ex.mem_addr[MEM_AW-1:0]),
      .wr_data    (ex.mem_data),
      .rd_word    (load_word),
      .clear_busy (clear_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= accept;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_instr_ff    <= s1_instr_in;
         s2_rf_we_ff    <= ex.rf_we;
         s2_load_ff     <= ex.load;
         s2_wa_ff       <= s1_instr_ff.first_reg[REG_AW-1:0];
         s2_result_ff   <= ex.result;
         s2_next_pc_ff  <= ex.next_pc;
         s2_err_ff      <= ex.err;
         out_next_pc_ff <= s2_next_pc_ff;
         out_err_ff     <= s2_err_ff;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_next_pc    = out_next_pc_ff;
   assign rsp_error_code = out_err_ff;

   // A faulting instruction always reports a next address of zero.
   `MSE_ASSERT_IMPLY(a_error_zero_pc, rsp_valid && (rsp_error_code != ERR_OK), rsp_next_pc == '0)
   // Register zero is never written.
   `MSE_ASSERT_IMPLY(a_no_zero_write, rf_commit.we, rf_commit.addr != REG_ZERO)
   // A store only changes memory when its instruction passed every check.
   `MSE_ASSERT_IMPLY(a_store_ok, dm_wr_en, ex.err == ERR_OK)
   // While memory is being cleared the pipeline holds no instruction.
   `MSE_ASSERT_IMPLY(a_clear_idle, clear_busy, !s1_valid_ff && !s2_valid_ff && !out_valid_ff)
   // The clearing pass runs once after reset and never starts again.
   `MSE_ASSERT_NEXT(a_clear_once, !clear_busy, !clear_busy)

endmodule

`default_nettype wire

// ===== hw/rtl/mse_ram.sv =====
// ============================================================================
// MIPS subset execute unit: generic RAM
// Single write port, single read port, registered read data. A read of the
// entry written at the same edge returns the old contents.
// ============================================================================
`default_nettype none

module mse_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mse_regfile.sv =====
// ============================================================================
// MIPS subset execute unit: register file
// Two banked copies of the 32 x 32 register file give two read ports. Valid
// bits supply the reset contents, and a bypass covers writes that the
// registered read could not yet see.
// ============================================================================
`default_nettype none

module mse_regfile
   import mse_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [REG_AW-1:0] rd_addr0,
   input  logic [REG_AW-1:0] rd_addr1,
   input  wb_type            pend,
   input  wb_type            commit,
   output logic [XLEN-1:0]   rd_data0,
   output logic [XLEN-1:0]   rd_data1
);

   localparam logic [XLEN-1:0] MEM_SIZE_VALUE = XLEN'(MEM_BYTES);

   logic [NUM_REGS-1:0] valid_ff;
   logic                rd_valid0_ff;
   logic                rd_valid1_ff;
   logic [REG_AW-1:0]   rd_addr0_ff;
   logic [REG_AW-1:0]   rd_addr1_ff;
   wb_type              last_ff;
   logic [XLEN-1:0]     bank0_data;
   logic [XLEN-1:0]     bank1_data;
   logic [XLEN-1:0]     stored0;
   logic [XLEN-1:0]     stored1;

   mse_ram #(
      .WIDTH (XLEN),
      .DEPTH (NUM_REGS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (commit.we),
      .wr_addr (commit.addr),
      .wr_data (commit.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr0),
      .rd_data (bank0_data)
   );

   mse_ram #(
      .WIDTH (XLEN),
      .DEPTH (NUM_REGS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (commit.we),
      .wr_addr (commit.addr),
      .wr_data (commit.data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr1),
      .rd_data (bank1_data)
   );

   // The write committed at the read edge is remembered so that the next
   // item, whose read saw the old contents, still gets the new value.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         last_ff      <= '0;
         rd_valid0_ff <= 1'b0;
         rd_valid1_ff <= 1'b0;
      end else begin
         if (commit.we) begin
            valid_ff[commit.addr] <= 1'b1;
         end
         if (rd_en) begin
            last_ff      <= commit;
            rd_valid0_ff <= valid_ff[rd_addr0];
            rd_valid1_ff <= valid_ff[rd_addr1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr0_ff <= rd_addr0;
         rd_addr1_ff <= rd_addr1;
      end
   end

   // Never-written entries read as their reset contents.
   assign stored0 = rd_valid0_ff ? bank0_data :
                    ((rd_addr0_ff == REG_MEM_SIZE) ? MEM_SIZE_VALUE : '0);
   assign stored1 = rd_valid1_ff ? bank1_data :
                    ((rd_addr1_ff == REG_MEM_SIZE) ? MEM_SIZE_VALUE : '0);

   // The pending write of the item just ahead is the newest value.
   assign rd_data0 = (pend.we && (pend.addr == rd_addr0_ff)) ? pend.data :
                     (last_ff.we && (last_ff.addr == rd_addr0_ff)) ? last_ff.data : stored0;
   assign rd_data1 = (pend.we && (pend.addr == rd_addr1_ff)) ? pend.data :
                     (last_ff.we && (last_ff.addr == rd_addr1_ff)) ? last_ff.data : stored1;

endmodule

`default_nettype wire

// ===== hw/rtl/mse_datamem.sv =====
// ============================================================================
// MIPS subset execute unit: data memory
// Byte-addressed little-endian memory built from four byte lanes. Stores may
// start at any byte and wrap around the top; loads are word aligned. A
// clearing pass zeroes every row after reset.
// ============================================================================
`default_nettype none

module mse_datamem
   import mse_pkg::*;
#(
   parameter int MEM_BYTES = MEM_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [$clog2(MEM_BYTES)-3:0] rd_row,
   input  logic                         wr_en,
   input  logic [$clog2(MEM_BYTES)-1:0] wr_addr,
   input  logic [XLEN-1:0]              wr_data,
   output logic [XLEN-1:0]              rd_word,
   output logic                         clear_busy
);

   localparam int AW    = $clog2(MEM_BYTES);
   localparam int ROWS  = MEM_BYTES / 4;
   localparam int ROW_W = AW - 2;
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic             clr_busy_ff;
   logic [ROW_W-1:0] clr_row_ff;
   logic [ROW_W-1:0] clr_row_in;
   logic [ROW_W-1:0] wr_row;
   logic [1:0]       wr_off;

   assign wr_row     = wr_addr[AW-1:2];
   assign wr_off     = wr_addr[1:0];
   assign clr_row_in = clr_row_ff + ROW_W'(1);
   assign clear_busy = clr_busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_in;
         if (clr_row_ff == LAST_ROW) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   for (genvar lane = 0; lane < 4; lane++) begin : g_lane
      localparam logic [1:0] LANE = 2'(lane);

      logic [1:0]        byte_sel;
      logic [ROW_W-1:0]  row;
      logic              lane_we;
      logic [BYTE_W-1:0] lane_wdata;

      // Lanes below the start offset hold the bytes that spill into the
      // following row.
      assign byte_sel   = LANE - wr_off;
      assign lane_we    = clr_busy_ff | wr_en;
      assign row        = clr_busy_ff ? clr_row_ff :
                          ((LANE < wr_off) ? wr_row + ROW_W'(1) : wr_row);
      assign lane_wdata = clr_busy_ff ? '0 : wr_data[{byte_sel, 3'b000} +: BYTE_W];

      mse_ram #(
         .WIDTH (BYTE_W),
         .DEPTH (ROWS)
      ) u_lane (
         .clock   (clock),
         .wr_en   (lane_we),
         .wr_addr (row),
         .wr_data (lane_wdata),
         .rd_en   (rd_en),
         .rd_addr (rd_row),
         .rd_data (rd_word[BYTE_W*lane +: BYTE_W])
      );
   end

endmodule

`default_nettype wire

// ===== hw/rtl/mse_execute.sv =====
// ============================================================================
// MIPS subset execute unit: execute logic
// Register checks, arithmetic, compare, branch and address generation for
// one instruction with its source operands already read.
// ============================================================================
`default_nettype none

module mse_execute
   import mse_pkg::*;
(
   input  instr_type       instr,
   input  logic [XLEN-1:0] op_x,
   input  logic [XLEN-1:0] op_y,
   output exec_type        ex
);

   logic [XLEN-1:0] product;
   logic [XLEN-1:0] mem_addr;
   logic            dst_ok;
   logic            alu_ok;
   logic            cmp_ok;
   logic            taken;
   logic            tgt_aligned;

   assign product     = op_x * op_y;
   assign mem_addr    = op_y + instr.immediate;
   assign dst_ok      = !instr.first_reg[REG_AW] && (instr.first_reg[REG_AW-1:0] != REG_ZERO);
   assign alu_ok      = dst_ok && !instr.second_reg[REG_AW] && !instr.third_reg[REG_AW];
   assign cmp_ok      = !instr.first_reg[REG_AW] && !instr.second_reg[REG_AW];
   assign taken       = (instr.func == OP_BEQ) ? (op_x == op_y) : (op_x != op_y);
   assign tgt_aligned = (instr.immediate[1:0] == 2'b00);

   always_comb begin
      ex          = '0;
      ex.err      = ERR_OK;
      ex.next_pc  = instr.pc + XLEN'(4);
      ex.result   = op_x + op_y;
      ex.mem_addr = mem_addr;
      ex.mem_data = op_x;

      case (instr.func)
         OP_ADD, OP_SUB, OP_MUL, OP_SLT: begin
            if (alu_ok) begin
               ex.rf_we = 1'b1;
               if (instr.func == OP_SUB) begin
                  ex.result = op_x - op_y;
               end else if (instr.func == OP_MUL) begin
                  ex.result = product;
               end else if (instr.func == OP_SLT) begin
                  ex.result = {{(XLEN-1){1'b0}}, ($signed(op_x) < $signed(op_y))};
               end
            end else begin
               ex.err = ERR_REG;
            end
         end
         OP_ADDI: begin
            if (dst_ok && !instr.second_reg[REG_AW]) begin
               ex.rf_we  = 1'b1;
               ex.result = op_x + instr.immediate;
            end else begin
               ex.err = ERR_REG;
            end
         end
         OP_BEQ, OP_BNE: begin
            if (!cmp_ok) begin
               ex.err = ERR_REG;
            end else if (taken) begin
               if (!tgt_aligned || (instr.immediate == '0)) begin
                  ex.err = ERR_TARGET;
               end else begin
                  ex.next_pc = instr.immediate + XLEN'(1);
               end
            end
         end
         OP_LW: begin
            if (!dst_ok || instr.third_reg[REG_AW]) begin
               ex.err = ERR_REG;
            end else if (mem_addr[1:0] != 2'b00) begin
               ex.err = ERR_ALIGN;
            end else begin
               ex.rf_we = 1'b1;
               ex.load  = 1'b1;
            end
         end
         OP_SW: begin
            if (instr.first_reg[REG_AW] || instr.third_reg[REG_AW]) begin
               ex.err = ERR_REG;
            end else if (!tgt_aligned) begin
               // Only the offset is checked; the word may land unaligned.
               ex.err = ERR_ALIGN;
            end else begin
               ex.mem_we = 1'b1;
            end
         end
         OP_J: begin
            if (tgt_aligned) begin
               ex.next_pc = instr.immediate + XLEN'(1);
            end else begin
               ex.err = ERR_TARGET;
            end
         end
         default: begin
            ex.err = ERR_OPCODE;
         end
      endcase

      if (ex.err != ERR_OK) begin
         ex.next_pc = '0;
         ex.rf_we   = 1'b0;
         ex.load    = 1'b0;
         ex.mem_we  = 1'b0;
      end
   end

endmodule

`default_nettype wire
